[hdl/dop_pkg.sv]
// -----------------------------------------------------------------------------
// dop_pkg
// Shared types and constants for the DHCP option parser.
// -----------------------------------------------------------------------------
package dop_pkg;

  localparam logic [7:0] TAG_PAD    = 8'd0;
  localparam logic [7:0] TAG_SUBNET = 8'd1;
  localparam logic [7:0] TAG_ROUTER = 8'd3;
  localparam logic [7:0] TAG_DNS    = 8'd6;
  localparam logic [7:0] TAG_LEASE  = 8'd51;
  localparam logic [7:0] TAG_TYPE   = 8'd53;
  localparam logic [7:0] TAG_SERVER = 8'd54;
  localparam logic [7:0] TAG_RENEW  = 8'd58;
  localparam logic [7:0] TAG_REBIND = 8'd59;
  localparam logic [7:0] TAG_END    = 8'd255;

  // Accepted input byte as held in the input register
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_item_t;

  // One packet summary
  typedef struct packed {
    logic        parse_ok;
    logic        type_seen;
    logic [7:0]  message_type;
    logic [31:0] subnet_mask;
    logic [31:0] router_address;
    logic [31:0] dns_primary;
    logic [31:0] dns_backup;
    logic [31:0] server_identifier;
    logic [31:0] lease_seconds;
    logic [31:0] renew_seconds;
    logic [31:0] rebind_seconds;
  } summary_t;

endpackage

[hdl/dhcp_option_parser_unit.sv]
// -----------------------------------------------------------------------------
// dhcp_option_parser_unit
// DHCP options-area parser: cookie check, TLV walk, one summary per packet.
// -----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | data_byte, last_byte
//  out     | out_valid / out_ready| parse_ok, type_seen, message_type, fields
//
//  One byte per cycle unless a last byte waits on a full result register; the
//  parse is combinational logic between input and state/result registers.
//  The summary loads when the core takes the last byte from the input register.
//  Reset (rst, synchronous) returns the core to the cookie phase with all core fields zero.
//  A last byte waits in the input register while the result register is full
//  and not taken; other bytes keep flowing regardless of the output side.
// -----------------------------------------------------------------------------
module dhcp_option_parser_unit
  import dop_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        parse_ok,
  output logic        type_seen,
  output logic [7:0]  message_type,
  output logic [31:0] subnet_mask,
  output logic [31:0] router_address,
  output logic [31:0] dns_primary,
  output logic [31:0] dns_backup,
  output logic [31:0] server_identifier,
  output logic [31:0] lease_seconds,
  output logic [31:0] renew_seconds,
  output logic [31:0] rebind_seconds
);

  logic     item_valid;
  in_item_t item;
  logic     take;
  logic     emit;
  logic     out_free;
  summary_t summary;
  summary_t summary_q;

  dop_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  dop_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .emit       (emit),
    .summary    (summary)
  );

  dop_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (emit),
    .summary_in (summary),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .summary_q  (summary_q)
  );

  assign parse_ok          = summary_q.parse_ok;
  assign type_seen         = summary_q.type_seen;
  assign message_type      = summary_q.message_type;
  assign subnet_mask       = summary_q.subnet_mask;
  assign router_address    = summary_q.router_address;
  assign dns_primary       = summary_q.dns_primary;
  assign dns_backup        = summary_q.dns_backup;
  assign server_identifier = summary_q.server_identifier;
  assign lease_seconds     = summary_q.lease_seconds;
  assign renew_seconds     = summary_q.renew_seconds;
  assign rebind_seconds    = summary_q.rebind_seconds;

  // never overwrite a summary that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || out_ready))
    else $error("summary loaded over a pending transaction");

  // input stalls only behind a last byte blocked by a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (item_valid && item.last && out_valid && !out_ready))
    else $error("input stalled without a blocked last byte");

  // a taken result with no new load leaves the result register empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !emit) |=> !out_valid)
    else $error("result still valid after transaction");

endmodule

[hdl/dop_in_stage.sv]
// -----------------------------------------------------------------------------
// dop_in_stage
// Input register: holds one option byte until the parse core takes it.
// -----------------------------------------------------------------------------
module dop_in_stage
  import dop_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       take,
  output logic       item_valid,
  output in_item_t   item
);

  assign in_ready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item.data <= data_byte;
      item.last <= last_byte;
    end
  end

endmodule

[hdl/dop_core.sv]
// -----------------------------------------------------------------------------
// dop_core
// Option walk: cookie check, tag-length-value tracking and field capture.
// -----------------------------------------------------------------------------
module dop_core
  import dop_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  in_item_t item,
  input  logic     out_free,
  output logic     take,
  output logic     emit,
  output summary_t summary
);

  typedef enum logic [2:0] {
    PH_COOKIE, PH_TAG, PH_LEN, PH_VALUE, PH_DONE, PH_BAD
  } phase_t;

  localparam logic [2:0] SLOT_SUBNET = 3'd0;
  localparam logic [2:0] SLOT_ROUTER = 3'd1;
  localparam logic [2:0] SLOT_DNS1   = 3'd2;
  localparam logic [2:0] SLOT_DNS2   = 3'd3;
  localparam logic [2:0] SLOT_SERVER = 3'd4;
  localparam logic [2:0] SLOT_LEASE  = 3'd5;
  localparam logic [2:0] SLOT_RENEW  = 3'd6;
  localparam logic [2:0] SLOT_REBIND = 3'd7;
  localparam logic [3:0] POS_SAT     = 4'd8;

  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    cookie_byte = 8'd99;
      2'd1:    cookie_byte = 8'd130;
      2'd2:    cookie_byte = 8'd83;
      default: cookie_byte = 8'd99;
    endcase
  endfunction

  phase_t      phase, phase_next;
  logic [3:0]  pos, pos_next;       // cookie index or value index, saturates at 8
  logic [7:0]  tag, tag_next;
  logic [7:0]  remaining, remaining_next;
  logic [31:0] fields [8];
  logic [31:0] fields_next [8];
  logic [7:0]  type_value, type_value_next;
  logic        type_found, type_found_next;
  logic        cookie_ok, cookie_ok_next;
  logic        end_found, end_found_next;

  logic        slot_hit;
  logic [2:0]  slot;
  logic [1:0]  lane;
  logic [7:0]  b;

  assign b    = item.data;
  assign take = item_valid && (!item.last || out_free);
  assign emit = take && item.last;
  assign lane = 2'd3 - pos[1:0];

  always_comb begin
    slot_hit = 1'b1;
    case (tag)
      TAG_SUBNET: slot = SLOT_SUBNET;
      TAG_ROUTER: slot = SLOT_ROUTER;
      TAG_DNS:    slot = SLOT_DNS1;
      TAG_SERVER: slot = SLOT_SERVER;
      TAG_LEASE:  slot = SLOT_LEASE;
      TAG_RENEW:  slot = SLOT_RENEW;
      TAG_REBIND: slot = SLOT_REBIND;
      default: begin
        slot     = SLOT_SUBNET;
        slot_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    phase_next      = phase;
    pos_next        = pos;
    tag_next        = tag;
    remaining_next  = remaining;
    fields_next     = fields;
    type_value_next = type_value;
    type_found_next = type_found;
    cookie_ok_next  = cookie_ok;
    end_found_next  = end_found;
    case (phase)
      PH_COOKIE: begin
        if (b != cookie_byte(pos[1:0])) begin
          cookie_ok_next = 1'b0;
          phase_next     = PH_BAD;
        end else if (pos[1:0] == 2'd3) begin
          pos_next   = '0;
          phase_next = PH_TAG;
        end else begin
          pos_next = pos + 4'd1;
        end
      end
      PH_TAG: begin
        if (b == TAG_END) begin
          end_found_next = 1'b1;
          phase_next     = PH_DONE;
        end else if (b != TAG_PAD) begin
          tag_next   = b;
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        if (slot_hit) fields_next[slot] = '0;
        if (tag == TAG_DNS && b > 8'd4) fields_next[SLOT_DNS2] = '0;
        if (tag == TAG_TYPE) begin
          type_found_next = 1'b1;
          type_value_next = '0;
        end
        remaining_next = b;
        pos_next       = '0;
        phase_next     = (b == 8'd0) ? PH_TAG : PH_VALUE;
      end
      PH_VALUE: begin
        // byte i at bits 31-8(i%4); bytes past the fourth drop but DNS i<8 (backup)
        if (slot_hit && pos < 4'd4)
          fields_next[slot][{lane, 3'b000} +: 8] = fields[slot][{lane, 3'b000} +: 8] | b;
        if (tag == TAG_DNS && pos >= 4'd4 && pos < POS_SAT)
          fields_next[SLOT_DNS2][{lane, 3'b000} +: 8] =
            fields[SLOT_DNS2][{lane, 3'b000} +: 8] | b;
        if (tag == TAG_TYPE && pos == 4'd0) type_value_next = b;
        if (pos < POS_SAT) pos_next = pos + 4'd1;
        remaining_next = remaining - 8'd1;
        if (remaining == 8'd1) phase_next = PH_TAG;
      end
      default: ;
    endcase
  end

  always_comb begin
    summary.parse_ok          = cookie_ok_next && end_found_next;
    summary.type_seen         = type_found_next;
    summary.message_type      = type_value_next;
    summary.subnet_mask       = fields_next[SLOT_SUBNET];
    summary.router_address    = fields_next[SLOT_ROUTER];
    summary.dns_primary       = fields_next[SLOT_DNS1];
    summary.dns_backup        = fields_next[SLOT_DNS2];
    summary.server_identifier = fields_next[SLOT_SERVER];
    summary.lease_seconds     = fields_next[SLOT_LEASE];
    summary.renew_seconds     = fields_next[SLOT_RENEW];
    summary.rebind_seconds    = fields_next[SLOT_REBIND];
  end

  always_ff @(posedge clk) begin
    if (rst || emit) begin
      // start the next packet from a clean state
      phase      <= PH_COOKIE;
      pos        <= '0;
      tag        <= '0;
      remaining  <= '0;
      fields     <= '{default: '0};
      type_value <= '0;
      type_found <= 1'b0;
      cookie_ok  <= 1'b1;
      end_found  <= 1'b0;
    end else if (take) begin
      phase      <= phase_next;
      pos        <= pos_next;
      tag        <= tag_next;
      remaining  <= remaining_next;
      fields     <= fields_next;
      type_value <= type_value_next;
      type_found <= type_found_next;
      cookie_ok  <= cookie_ok_next;
      end_found  <= end_found_next;
    end
  end

endmodule

[hdl/dop_out_stage.sv]
// -----------------------------------------------------------------------------
// dop_out_stage
// Result register: holds one packet summary until the consumer takes it.
// -----------------------------------------------------------------------------
module dop_out_stage
  import dop_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     load,
  input  summary_t summary_in,
  output logic     out_free,
  output logic     out_valid,
  input  logic     out_ready,
  output summary_t summary_q
);

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      summary_q <= summary_in;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for dhcp_option_parser_unit. Feeds DHCP options areas
// a byte per transaction, predicts each packet summary with an in-bench TLV
// walk and compares every summary field as it leaves the block.
// -----------------------------------------------------------------------------
module tb;
  import dop_pkg::*;

  localparam int          ITEM_TARGET  = 1850;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          DRAIN_CYCLES = 12;
  localparam int          HOLD_CYCLES  = 400;
  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;

  typedef enum logic [2:0] {
    SCAN_COOKIE, SCAN_TAG, SCAN_LENGTH, SCAN_VALUE, SCAN_DONE, SCAN_REJECT
  } scan_phase_t;

  typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PATTERN} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        parse_ok;
  logic        type_seen;
  logic [7:0]  message_type;
  logic [31:0] subnet_mask;
  logic [31:0] router_address;
  logic [31:0] dns_primary;
  logic [31:0] dns_backup;
  logic [31:0] server_identifier;
  logic [31:0] lease_seconds;
  logic [31:0] renew_seconds;
  logic [31:0] rebind_seconds;

  dhcp_option_parser_unit dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .data_byte         (data_byte),
    .last_byte         (last_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .parse_ok          (parse_ok),
    .type_seen         (type_seen),
    .message_type      (message_type),
    .subnet_mask       (subnet_mask),
    .router_address    (router_address),
    .dns_primary       (dns_primary),
    .dns_backup        (dns_backup),
    .server_identifier (server_identifier),
    .lease_seconds     (lease_seconds),
    .renew_seconds     (renew_seconds),
    .rebind_seconds    (rebind_seconds)
  );

  // Option walk mirror
  scan_phase_t scan_phase;
  logic [7:0]  value_index;
  logic [7:0]  option_tag;
  logic [7:0]  value_left;
  logic        cookie_ok;
  logic        end_seen;
  summary_t    gathered;
  summary_t    expected_summaries[$];

  logic [7:0]  pkt_bytes[$];
  int          burst_left;
  int          tx_gap_max;
  int          items_sent;
  int          packets_sent;
  int          summaries_checked;
  int          mismatches;
  int          cycle_count;
  rx_mode_t    rx_mode;
  int          rx_hold_left;
  logic [7:0]  rx_pattern;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  task automatic restart_scan();
    scan_phase  = SCAN_COOKIE;
    value_index = '0;
    option_tag  = '0;
    value_left  = '0;
    cookie_ok   = 1'b1;
    end_seen    = 1'b0;
    gathered    = '0;
  endtask

  task automatic parse_option_byte(input logic [7:0] b, input logic lst);
    logic [31:0] lane;
    // byte i of a value lands at bits 31-8i; DNS backup reuses the lane of i-4
    lane = {b, 24'h0} >> (8 * value_index[1:0]);
    case (scan_phase)
      SCAN_COOKIE: begin
        if (b != MAGIC_COOKIE[8 * (3 - value_index[1:0]) +: 8]) begin
          cookie_ok  = 1'b0;
          scan_phase = SCAN_REJECT;
        end else if (value_index >= 8'd3) begin
          value_index = '0;
          scan_phase  = SCAN_TAG;
        end else begin
          value_index++;
        end
      end
      SCAN_TAG: begin
        if (b == TAG_END) begin
          end_seen   = 1'b1;
          scan_phase = SCAN_DONE;
        end else if (b != TAG_PAD) begin
          option_tag = b;
          scan_phase = SCAN_LENGTH;
        end
      end
      SCAN_LENGTH: begin
        case (option_tag)
          TAG_SUBNET: gathered.subnet_mask       = '0;
          TAG_ROUTER: gathered.router_address    = '0;
          TAG_SERVER: gathered.server_identifier = '0;
          TAG_LEASE:  gathered.lease_seconds     = '0;
          TAG_RENEW:  gathered.renew_seconds     = '0;
          TAG_REBIND: gathered.rebind_seconds    = '0;
          TAG_DNS: begin
            gathered.dns_primary = '0;
            if (b > 8'd4) gathered.dns_backup = '0;
          end
          TAG_TYPE: begin
            gathered.type_seen    = 1'b1;
            gathered.message_type = '0;
          end
          default: ;
        endcase
        value_left  = b;
        value_index = '0;
        scan_phase  = (b == 8'd0) ? SCAN_TAG : SCAN_VALUE;
      end
      SCAN_VALUE: begin
        if (value_index < 8'd4) begin
          case (option_tag)
            TAG_SUBNET: gathered.subnet_mask       |= lane;
            TAG_ROUTER: gathered.router_address    |= lane;
            TAG_DNS:    gathered.dns_primary       |= lane;
            TAG_SERVER: gathered.server_identifier |= lane;
            TAG_LEASE:  gathered.lease_seconds     |= lane;
            TAG_RENEW:  gathered.renew_seconds     |= lane;
            TAG_REBIND: gathered.rebind_seconds    |= lane;
            TAG_TYPE:   if (value_index == 8'd0) gathered.message_type = b;
            default: ;
          endcase
        end else if (value_index < 8'd8 && option_tag == TAG_DNS) begin
          gathered.dns_backup |= lane;
        end
        if (value_index != 8'd255) value_index++;
        value_left--;
        if (value_left == 8'd0) scan_phase = SCAN_TAG;
      end
      default: ;
    endcase
    if (lst) begin
      gathered.parse_ok = cookie_ok && end_seen;
      expected_summaries.push_back(gathered);
      restart_scan();
    end
  endtask

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      last_byte <= 1'($urandom);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gap_max > 0) idle_input($urandom_range(0, tx_gap_max));
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_option_byte(b, lst);
    items_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets_sent++;
  endtask

  task automatic add_word(input logic [31:0] w);
    for (int k = 3; k >= 0; k--) pkt_bytes.push_back(w[8 * k +: 8]);
  endtask

  task automatic add_option(input logic [7:0] tag, input logic [7:0] len);
    pkt_bytes.push_back(tag);
    pkt_bytes.push_back(len);
    repeat (len) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic build_wellformed(input logic with_long);
    int         n_opts;
    int         pick;
    logic [7:0] tag;
    logic [7:0] len;
    pkt_bytes.delete();
    add_word(MAGIC_COOKIE);
    n_opts = $urandom_range(0, 6);
    repeat (n_opts) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        pkt_bytes.push_back(TAG_PAD);
      end else begin
        case (pick)
          1:       tag = TAG_SUBNET;
          2:       tag = TAG_ROUTER;
          3:       tag = TAG_DNS;
          4:       tag = TAG_SERVER;
          5:       tag = TAG_LEASE;
          6:       tag = TAG_RENEW;
          7:       tag = TAG_REBIND;
          8:       tag = TAG_TYPE;
          default: tag = 8'($urandom_range(1, 254));
        endcase
        if (tag == TAG_TYPE) len = 8'd1;
        else if (tag == TAG_DNS) len = $urandom_range(0, 1) ? 8'd8 : 8'd4;
        else len = 8'd4;
        // odd lengths now and then: short, long, zero
        if ($urandom_range(0, 3) == 0) len = 8'($urandom_range(0, 10));
        add_option(tag, len);
      end
    end
    if (with_long) add_option(8'($urandom_range(60, 250)), 8'd255);
    if ($urandom_range(0, 6) != 0) begin
      pkt_bytes.push_back(TAG_END);
      repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
    end else if (pkt_bytes.size() > 5) begin
      // cut off somewhere in the options, never reaching an end tag
      repeat ($urandom_range(0, pkt_bytes.size() - 5)) void'(pkt_bytes.pop_back());
    end
  endtask

  task automatic build_broken();
    int         pos;
    logic [7:0] flip;
    pkt_bytes.delete();
    case ($urandom_range(0, 2))
      0: begin
        add_word(MAGIC_COOKIE);
        pos  = $urandom_range(0, 3);
        flip = 8'($urandom_range(1, 255));
        pkt_bytes[pos] = pkt_bytes[pos] ^ flip;
        if ($urandom_range(0, 1)) add_option(TAG_TYPE, 8'd1);
        if ($urandom_range(0, 1)) pkt_bytes.push_back(TAG_END);
        repeat ($urandom_range(0, 6)) pkt_bytes.push_back(8'($urandom));
      end
      1: repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom));
      default: begin
        add_word(MAGIC_COOKIE);
        repeat ($urandom_range(0, 3)) void'(pkt_bytes.pop_back());
      end
    endcase
  endtask

  task automatic wait_for_summaries();
    while (expected_summaries.size() != 0) idle_input(1);
    idle_input(DRAIN_CYCLES);
  endtask

  // Receiver: a long hold-off overrides the current stall mode
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default: begin
          out_ready  <= rx_pattern[0];
          rx_pattern =  {rx_pattern[0], rx_pattern[7:1]};
        end
      endcase
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_summaries
    summary_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_summaries.size() == 0) begin
        $error("summary transaction with no packet outstanding");
        mismatches++;
      end else begin
        want = expected_summaries.pop_front();
        check_field("parse_ok",          32'(want.parse_ok),     32'(parse_ok));
        check_field("type_seen",         32'(want.type_seen),    32'(type_seen));
        check_field("message_type",      32'(want.message_type), 32'(message_type));
        check_field("subnet_mask",       want.subnet_mask,       subnet_mask);
        check_field("router_address",    want.router_address,    router_address);
        check_field("dns_primary",       want.dns_primary,       dns_primary);
        check_field("dns_backup",        want.dns_backup,        dns_backup);
        check_field("server_identifier", want.server_identifier, server_identifier);
        check_field("lease_seconds",     want.lease_seconds,     lease_seconds);
        check_field("renew_seconds",     want.renew_seconds,     renew_seconds);
        check_field("rebind_seconds",    want.rebind_seconds,    rebind_seconds);
        summaries_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles, %0d summaries outstanding",
               cycle_count, expected_summaries.size());
      $display("** dhcp_option_parser_unit: FAILED **");
      $finish;
    end
  end

  // Pad, message type, DNS pair, zero-length lease, short subnet, end, junk
  task automatic test_full_option_set();
    pkt_bytes.delete();
    add_word(MAGIC_COOKIE);
    pkt_bytes.push_back(TAG_PAD);
    pkt_bytes.push_back(TAG_TYPE);
    pkt_bytes.push_back(8'd1);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(TAG_DNS);
    pkt_bytes.push_back(8'd8);
    add_word(32'h8001_FE7F);
    add_word(32'hAA55_00FF);
    pkt_bytes.push_back(TAG_LEASE);
    pkt_bytes.push_back(8'd0);
    pkt_bytes.push_back(TAG_SUBNET);
    pkt_bytes.push_back(8'd2);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(TAG_END);
    pkt_bytes.push_back(8'h7E);
    send_packet();
  endtask

  task automatic test_bad_cookie();
    pkt_bytes.delete();
    pkt_bytes.push_back(MAGIC_COOKIE[31:24]);
    pkt_bytes.push_back(8'h00);
    send_packet();
  endtask

  task automatic test_single_byte_packet();
    pkt_bytes.delete();
    pkt_bytes.push_back(TAG_END);
    send_packet();
  endtask

  task automatic test_random_packets();
    int n;
    n = 0;
    while (items_sent < ITEM_TARGET) begin
      if (n % 12 == 0) begin
        rx_mode    = rx_mode_t'($urandom_range(0, 3));
        rx_pattern = 8'($urandom_range(1, 255));
        case ($urandom_range(0, 2))
          0:       tx_gap_max = 0;
          1:       tx_gap_max = 3;
          default: tx_gap_max = 10;
        endcase
      end
      if ($urandom_range(0, 4) == 0) build_broken();
      else build_wellformed(n % 150 == 75);
      send_packet();
      n++;
    end
  endtask

  // Stall the output long enough that a last byte backs up the input side
  task automatic test_output_hold_off();
    tx_gap_max = 0;
    rx_mode    = RX_ALWAYS;
    idle_input(1);
    rx_hold_left = HOLD_CYCLES;
    repeat (8) begin
      pkt_bytes.delete();
      add_word(MAGIC_COOKIE);
      add_option(TAG_TYPE, 8'd1);
      pkt_bytes.push_back(TAG_END);
      send_packet();
    end
  endtask

  // Let the block run dry before each packet
  task automatic test_drain_pause();
    tx_gap_max = 2;
    rx_mode    = RX_RANDOM;
    repeat (3) begin
      wait_for_summaries();
      build_wellformed(1'b0);
      send_packet();
    end
  endtask

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    data_byte         = '0;
    last_byte         = 1'b0;
    out_ready         = 1'b0;
    rx_mode           = RX_ALWAYS;
    rx_hold_left      = 0;
    rx_pattern        = 8'b1011_0010;
    burst_left        = 0;
    tx_gap_max        = 0;
    items_sent        = 0;
    packets_sent      = 0;
    summaries_checked = 0;
    mismatches        = 0;
    cycle_count       = 0;
    restart_scan();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_full_option_set();
    test_bad_cookie();
    test_single_byte_packet();
    test_random_packets();
    test_output_hold_off();
    test_drain_pause();

    rx_mode = RX_ALWAYS;
    wait_for_summaries();
    $display("Sent %0d option bytes in %0d packets under mixed gaps and output stalls;",
             items_sent, packets_sent);
    $display("checked %0d summaries, %0d field mismatches", summaries_checked, mismatches);
    if (mismatches == 0 && expected_summaries.size() == 0)
      $display("** dhcp_option_parser_unit: PASSED **");
    else
      $display("** dhcp_option_parser_unit: FAILED **");
    $finish;
  end

endmodule

[sim.f]
hdl/dop_pkg.sv
hdl/dop_in_stage.sv
hdl/dop_core.sv
hdl/dop_out_stage.sv
hdl/dhcp_option_parser_unit.sv
tb/tb.sv
